/* hw/rtl/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define SAUC_ASSERT_IMPL(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// next-cycle implication
`define SAUC_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define SAUC_ASSERT_IMPL(lbl, clk, rst_n, a, c)
`define SAUC_ASSERT_NEXT(lbl, clk, rst_n, a, c)
`endif
`endif

/* hw/rtl/sauc_pkg.sv */
package sauc_pkg;

    localparam int TEXT_MAX   = 4096;
    localparam int ALPHABET   = 26;
    localparam int NODE_CAP   = 2 * TEXT_MAX + 2;
    localparam int NODE_DEPTH = 2 * TEXT_MAX;
    localparam int NODE_W     = $clog2(NODE_DEPTH);
    localparam int TT_DEPTH   = NODE_DEPTH * ALPHABET;
    localparam int TT_AW      = $clog2(TT_DEPTH);
    localparam int SYM_W      = 5;
    localparam int KIND_W     = 2;
    localparam int K_W        = $clog2(ALPHABET);
    localparam int CNT_W      = 24;

    localparam logic [KIND_W-1:0] K_APPEND = 2'd0;
    localparam logic [KIND_W-1:0] K_QUERY  = 2'd1;
    localparam logic [KIND_W-1:0] K_ENDQ   = 2'd2;
    localparam logic [KIND_W-1:0] K_FINISH = 2'd3;

    localparam logic [NODE_W-1:0] ROOT_NODE = NODE_W'(1);

    typedef enum logic [5:0] {
        ST_BOOT, ST_IDLE,
        ST_A0, ST_A1, ST_CLRNP, ST_WRD, ST_WCHK, ST_WLINK, ST_QRD, ST_QCHK,
        ST_CLLNK, ST_CLQ, ST_CLNP, ST_CPRD, ST_CPWR, ST_RRD, ST_RCHK, ST_RLINK,
        ST_MRD, ST_MCHK, ST_MLINK, ST_MBEST,
        ST_FSTART, ST_F1RD, ST_F1CHK, ST_F2RD, ST_F2CHK, ST_FNEXT,
        ST_GRD, ST_GMID, ST_GCHK, ST_CLRROOT, ST_EMIT
    } state_t;

    typedef enum logic [4:0] {
        OP_IDLE,
        OP_A0, OP_A1, OP_CLRNP, OP_WRD, OP_WCHK, OP_WLINK, OP_QRD, OP_QCHK,
        OP_CLLNK, OP_CLQ, OP_CLNP, OP_CPRD, OP_CPWR, OP_RRD, OP_RCHK, OP_RLINK,
        OP_MRD, OP_MCHK, OP_MLINK, OP_MBEST,
        OP_FSTART, OP_F1RD, OP_F1CHK, OP_F2RD, OP_F2CHK, OP_FNEXT,
        OP_GRD, OP_GMID, OP_GCHK, OP_CLRROOT, OP_EMIT
    } op_t;

    typedef enum logic [2:0] {
        CLS_NONE, CLS_APPEND, CLS_MATCH, CLS_ENDQ, CLS_FINISH
    } cls_t;

    typedef struct packed {
        op_t  op;
        logic take;
    } cmd_t;

    typedef struct packed {
        cls_t cls;
        logic drop;
        logic tt_zero;
        logic link_zero;
        logic len_match;
        logic redirect;
        logic k_last;
        logic best_zero;
        logic best_full;
        logic j_zero;
        logic i_two;
        logic i_end;
        logic few_nodes;
        logic out_busy;
    } status_t;

    function automatic logic [TT_AW-1:0] tt_addr(input logic [NODE_W-1:0] node,
                                                 input logic [SYM_W-1:0] sym);
        tt_addr = TT_AW'(node) * TT_AW'(ALPHABET) + TT_AW'(sym);
    endfunction

endpackage

/* hw/rtl/sauc_if.sv */
interface sauc_in_if;
    logic                         valid;
    logic                         ready;
    logic [sauc_pkg::KIND_W-1:0]  kind;
    logic [sauc_pkg::SYM_W-1:0]   symbol;
    modport source  (output valid, output kind, output symbol, input ready);
    modport sink    (input valid, input kind, input symbol, output ready);
    modport monitor (input valid, input kind, input symbol, input ready);
endinterface

interface sauc_out_if;
    logic                         valid;
    logic                         ready;
    logic [sauc_pkg::CNT_W-1:0]   unique_count;
    logic                         overflow;
    modport source  (output valid, output unique_count, output overflow, input ready);
    modport sink    (input valid, input unique_count, input overflow, output ready);
    modport monitor (input valid, input unique_count, input overflow, input ready);
endinterface

/* hw/rtl/suffix_automaton_unique_substrings_core.sv */
// Query symbol: check the edge, then update the best match or follow a suffix link.
// End-of-query is handled in idle. Text symbol: read the last node's length, clear the
// new node's row, walk suffix links adding edges until one exists; a split clones that
// node, copies its row and redirects edges. Finish: raise best matches, count nodes,
// clear the root row, emit. One word in flight: the next waits until that work completes.
// Reset (async, rst_n low): control clears; a pass clears the root row first.
`include "assert_macros.svh"

module suffix_automaton_unique_substrings_core (
    input  logic              clk,
    input  logic              rst_n,
    sauc_in_if.sink           item,
    sauc_out_if.source        result
);

    // controller and datapath talk only through these two structs
    sauc_pkg::cmd_t    cmd;
    sauc_pkg::status_t st;

    // assertion terms
    logic finish_take;
    logic emit_go;

    sauc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item.valid),
        .in_ready (item.ready),
        .st       (st),
        .cmd      (cmd)
    );

    // datapath owns the node memories and the output word register
    sauc_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .st           (st),
        .kind         (item.kind),
        .symbol       (item.symbol),
        .out_valid    (result.valid),
        .out_ready    (result.ready),
        .out_count    (result.unique_count),
        .out_overflow (result.overflow)
    );

    assign finish_take = item.valid && item.ready && (item.kind == sauc_pkg::K_FINISH);
    assign emit_go     = (cmd.op == sauc_pkg::OP_EMIT) && !st.out_busy;

    // a finish word keeps the input closed while the count is built
    `SAUC_ASSERT_NEXT(a_finish_busy, clk, rst_n, finish_take, !item.ready)
    // emitting with a free slot always presents a word next cycle
    `SAUC_ASSERT_NEXT(a_emit_word, clk, rst_n, emit_go, result.valid)

endmodule

/* hw/rtl/sauc_ctrl.sv */
module sauc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  sauc_pkg::status_t st,
    output sauc_pkg::cmd_t    cmd
);

    sauc_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sauc_pkg::ST_BOOT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sauc_pkg::ST_BOOT:    if (st.k_last) state_next = sauc_pkg::ST_IDLE;
            sauc_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (st.cls)
                        sauc_pkg::CLS_APPEND: state_next = sauc_pkg::ST_A0;
                        sauc_pkg::CLS_MATCH:  state_next = sauc_pkg::ST_MRD;
                        sauc_pkg::CLS_FINISH: state_next = sauc_pkg::ST_FSTART;
                        default:              state_next = sauc_pkg::ST_IDLE;
                    endcase
                end
            end
            sauc_pkg::ST_A0:      state_next = sauc_pkg::ST_A1;
            sauc_pkg::ST_A1:
                state_next = st.drop ? sauc_pkg::ST_IDLE : sauc_pkg::ST_CLRNP;
            sauc_pkg::ST_CLRNP:   if (st.k_last) state_next = sauc_pkg::ST_WRD;
            sauc_pkg::ST_WRD:     state_next = sauc_pkg::ST_WCHK;
            sauc_pkg::ST_WCHK:
                state_next = st.tt_zero ? sauc_pkg::ST_WLINK : sauc_pkg::ST_QRD;
            sauc_pkg::ST_WLINK:
                state_next = st.link_zero ? sauc_pkg::ST_IDLE : sauc_pkg::ST_WRD;
            sauc_pkg::ST_QRD:     state_next = sauc_pkg::ST_QCHK;
            sauc_pkg::ST_QCHK:
                state_next = st.len_match ? sauc_pkg::ST_IDLE : sauc_pkg::ST_CLLNK;
            sauc_pkg::ST_CLLNK:   state_next = sauc_pkg::ST_CLQ;
            sauc_pkg::ST_CLQ:     state_next = sauc_pkg::ST_CLNP;
            sauc_pkg::ST_CLNP:    state_next = sauc_pkg::ST_CPRD;
            sauc_pkg::ST_CPRD:    state_next = sauc_pkg::ST_CPWR;
            sauc_pkg::ST_CPWR:
                state_next = st.k_last ? sauc_pkg::ST_RRD : sauc_pkg::ST_CPRD;
            sauc_pkg::ST_RRD:     state_next = sauc_pkg::ST_RCHK;
            sauc_pkg::ST_RCHK:
                state_next = st.redirect ? sauc_pkg::ST_RLINK : sauc_pkg::ST_IDLE;
            sauc_pkg::ST_RLINK:
                state_next = st.link_zero ? sauc_pkg::ST_IDLE : sauc_pkg::ST_RRD;
            sauc_pkg::ST_MRD:     state_next = sauc_pkg::ST_MCHK;
            sauc_pkg::ST_MCHK:
                state_next = st.tt_zero ? sauc_pkg::ST_MLINK : sauc_pkg::ST_MBEST;
            sauc_pkg::ST_MLINK:
                state_next = st.link_zero ? sauc_pkg::ST_IDLE : sauc_pkg::ST_MRD;
            sauc_pkg::ST_MBEST:   state_next = sauc_pkg::ST_IDLE;
            sauc_pkg::ST_FSTART:
                state_next = st.few_nodes ? sauc_pkg::ST_CLRROOT : sauc_pkg::ST_F1RD;
            sauc_pkg::ST_F1RD:    state_next = sauc_pkg::ST_F1CHK;
            sauc_pkg::ST_F1CHK:
                state_next = st.best_zero ? sauc_pkg::ST_FNEXT : sauc_pkg::ST_F2RD;
            sauc_pkg::ST_F2RD:
                state_next = st.j_zero ? sauc_pkg::ST_FNEXT : sauc_pkg::ST_F2CHK;
            sauc_pkg::ST_F2CHK:
                state_next = st.best_full ? sauc_pkg::ST_FNEXT : sauc_pkg::ST_F2RD;
            sauc_pkg::ST_FNEXT:
                state_next = st.i_two ? sauc_pkg::ST_GRD : sauc_pkg::ST_F1RD;
            sauc_pkg::ST_GRD:     state_next = sauc_pkg::ST_GMID;
            sauc_pkg::ST_GMID:    state_next = sauc_pkg::ST_GCHK;
            sauc_pkg::ST_GCHK:
                state_next = st.i_end ? sauc_pkg::ST_CLRROOT : sauc_pkg::ST_GRD;
            sauc_pkg::ST_CLRROOT: if (st.k_last) state_next = sauc_pkg::ST_EMIT;
            sauc_pkg::ST_EMIT:    if (!st.out_busy) state_next = sauc_pkg::ST_IDLE;
            default:              state_next = sauc_pkg::ST_BOOT;
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd.take = 1'b0;
        cmd.op   = sauc_pkg::OP_IDLE;
        case (state_reg)
            sauc_pkg::ST_BOOT:    cmd.op = sauc_pkg::OP_CLRROOT;
            sauc_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.take = in_valid;
                cmd.op   = sauc_pkg::OP_IDLE;
            end
            sauc_pkg::ST_A0:      cmd.op = sauc_pkg::OP_A0;
            sauc_pkg::ST_A1:      cmd.op = sauc_pkg::OP_A1;
            sauc_pkg::ST_CLRNP:   cmd.op = sauc_pkg::OP_CLRNP;
            sauc_pkg::ST_WRD:     cmd.op = sauc_pkg::OP_WRD;
            sauc_pkg::ST_WCHK:    cmd.op = sauc_pkg::OP_WCHK;
            sauc_pkg::ST_WLINK:   cmd.op = sauc_pkg::OP_WLINK;
            sauc_pkg::ST_QRD:     cmd.op = sauc_pkg::OP_QRD;
            sauc_pkg::ST_QCHK:    cmd.op = sauc_pkg::OP_QCHK;
            sauc_pkg::ST_CLLNK:   cmd.op = sauc_pkg::OP_CLLNK;
            sauc_pkg::ST_CLQ:     cmd.op = sauc_pkg::OP_CLQ;
            sauc_pkg::ST_CLNP:    cmd.op = sauc_pkg::OP_CLNP;
            sauc_pkg::ST_CPRD:    cmd.op = sauc_pkg::OP_CPRD;
            sauc_pkg::ST_CPWR:    cmd.op = sauc_pkg::OP_CPWR;
            sauc_pkg::ST_RRD:     cmd.op = sauc_pkg::OP_RRD;
            sauc_pkg::ST_RCHK:    cmd.op = sauc_pkg::OP_RCHK;
            sauc_pkg::ST_RLINK:   cmd.op = sauc_pkg::OP_RLINK;
            sauc_pkg::ST_MRD:     cmd.op = sauc_pkg::OP_MRD;
            sauc_pkg::ST_MCHK:    cmd.op = sauc_pkg::OP_MCHK;
            sauc_pkg::ST_MLINK:   cmd.op = sauc_pkg::OP_MLINK;
            sauc_pkg::ST_MBEST:   cmd.op = sauc_pkg::OP_MBEST;
            sauc_pkg::ST_FSTART:  cmd.op = sauc_pkg::OP_FSTART;
            sauc_pkg::ST_F1RD:    cmd.op = sauc_pkg::OP_F1RD;
            sauc_pkg::ST_F1CHK:   cmd.op = sauc_pkg::OP_F1CHK;
            sauc_pkg::ST_F2RD:    cmd.op = sauc_pkg::OP_F2RD;
            sauc_pkg::ST_F2CHK:   cmd.op = sauc_pkg::OP_F2CHK;
            sauc_pkg::ST_FNEXT:   cmd.op = sauc_pkg::OP_FNEXT;
            sauc_pkg::ST_GRD:     cmd.op = sauc_pkg::OP_GRD;
            sauc_pkg::ST_GMID:    cmd.op = sauc_pkg::OP_GMID;
            sauc_pkg::ST_GCHK:    cmd.op = sauc_pkg::OP_GCHK;
            sauc_pkg::ST_CLRROOT: cmd.op = sauc_pkg::OP_CLRROOT;
            sauc_pkg::ST_EMIT:    cmd.op = sauc_pkg::OP_EMIT;
            default:              cmd.op = sauc_pkg::OP_IDLE;
        endcase
    end

endmodule

/* hw/rtl/sauc_dp.sv */
module sauc_dp (
    input  logic                         clk,
    input  logic                         rst_n,
    input  sauc_pkg::cmd_t               cmd,
    output sauc_pkg::status_t            st,
    input  logic [sauc_pkg::KIND_W-1:0]  kind,
    input  logic [sauc_pkg::SYM_W-1:0]   symbol,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [sauc_pkg::CNT_W-1:0]   out_count,
    output logic                         out_overflow
);

    localparam int NW = sauc_pkg::NODE_W;
    localparam int AW = sauc_pkg::TT_AW;

    // memories: transitions, suffix links, node lengths, best match
    logic [NW-1:0] tt_mem   [sauc_pkg::TT_DEPTH];
    logic [NW-1:0] link_mem [sauc_pkg::NODE_DEPTH];
    logic [NW-1:0] len_mem  [sauc_pkg::NODE_DEPTH];
    logic [NW-1:0] best_mem [sauc_pkg::NODE_DEPTH];

    logic          tt_we, link_we, len_we, best_we;
    logic [AW-1:0] tt_waddr, tt_raddr;
    logic [NW-1:0] link_waddr, link_raddr, len_waddr, len_raddr, best_waddr, best_raddr;
    logic [NW-1:0] tt_wdata, link_wdata, len_wdata, best_wdata;
    logic [NW-1:0] tt_rdata_reg, link_rdata_reg, len_rdata_reg, best_rdata_reg;

    logic [NW-1:0] p_reg, p_next, np_reg, np_next, q_reg, q_next, cl_reg, cl_next;
    logic [NW-1:0] u_reg, u_next, j_reg, j_next, i_reg, i_next;
    logic [NW-1:0] lenp_reg, lenp_next, leni_reg, leni_next, besti_reg, besti_next;
    logic [NW-1:0] last_reg, last_next, ncount_reg, ncount_next;
    logic [NW-1:0] mnode_reg, mnode_next, mlen_reg, mlen_next;
    logic [sauc_pkg::SYM_W-1:0] c_reg, c_next;
    logic [sauc_pkg::K_W-1:0]   k_reg, k_next;
    logic [sauc_pkg::CNT_W-1:0] total_reg, total_next, ocount_reg, ocount_next;
    logic dropped_reg, dropped_next, ovalid_reg, ovalid_next, oovf_reg, oovf_next;

    logic [NW-1:0] lenp_inc, clipped, floor_v;
    logic [NW:0]   cap_sum;

    assign lenp_inc = lenp_reg + NW'(1);
    assign cap_sum  = (NW+1)'(ncount_reg) + (NW+1)'(2);
    assign clipped  = (mlen_reg > len_rdata_reg) ? len_rdata_reg : mlen_reg;
    assign floor_v  = (besti_reg > len_rdata_reg) ? besti_reg : len_rdata_reg;

    always_comb
    begin
        if (symbol >= sauc_pkg::SYM_W'(sauc_pkg::ALPHABET) &&
            (kind == sauc_pkg::K_APPEND || kind == sauc_pkg::K_QUERY))
        begin
            st.cls = sauc_pkg::CLS_NONE;
        end
        else
        begin
            case (kind)
                sauc_pkg::K_APPEND: st.cls = sauc_pkg::CLS_APPEND;
                sauc_pkg::K_QUERY:  st.cls = sauc_pkg::CLS_MATCH;
                sauc_pkg::K_ENDQ:   st.cls = sauc_pkg::CLS_ENDQ;
                default:            st.cls = sauc_pkg::CLS_FINISH;
            endcase
        end
        st.drop      = (len_rdata_reg >= NW'(sauc_pkg::TEXT_MAX)) ||
                       (cap_sum >= (NW+1)'(sauc_pkg::NODE_CAP));
        st.tt_zero   = (tt_rdata_reg == '0);
        st.link_zero = (link_rdata_reg == '0);
        st.len_match = (len_rdata_reg == lenp_inc);
        st.redirect  = (tt_rdata_reg == q_reg);
        st.k_last    = (k_reg == sauc_pkg::K_W'(sauc_pkg::ALPHABET - 1));
        st.best_zero = (best_rdata_reg == '0);
        st.best_full = (best_rdata_reg == len_rdata_reg);
        st.j_zero    = (j_reg == '0);
        st.i_two     = (i_reg == NW'(2));
        st.i_end     = (i_reg == ncount_reg);
        st.few_nodes = (ncount_reg < NW'(2));
        st.out_busy  = ovalid_reg && !out_ready;
    end

    always_comb
    begin
        p_next = p_reg; np_next = np_reg; q_next = q_reg; cl_next = cl_reg;
        u_next = u_reg; j_next = j_reg; i_next = i_reg;
        lenp_next = lenp_reg; leni_next = leni_reg; besti_next = besti_reg;
        last_next = last_reg; ncount_next = ncount_reg;
        mnode_next = mnode_reg; mlen_next = mlen_reg;
        c_next = c_reg; k_next = k_reg; total_next = total_reg;
        dropped_next = dropped_reg;
        ovalid_next = ovalid_reg && !out_ready;
        ocount_next = ocount_reg; oovf_next = oovf_reg;
        tt_we = 1'b0; tt_waddr = '0; tt_wdata = '0; tt_raddr = '0;
        link_we = 1'b0; link_waddr = '0; link_wdata = '0; link_raddr = '0;
        len_we = 1'b0; len_waddr = '0; len_wdata = '0; len_raddr = '0;
        best_we = 1'b0; best_waddr = '0; best_wdata = '0; best_raddr = '0;
        case (cmd.op)
            sauc_pkg::OP_IDLE:
            begin
                if (cmd.take)
                begin
                    c_next = symbol;
                    p_next = last_reg;
                    u_next = mnode_reg;
                    if (kind == sauc_pkg::K_ENDQ)
                    begin
                        mnode_next = sauc_pkg::ROOT_NODE;
                        mlen_next  = '0;
                    end
                end
            end
            sauc_pkg::OP_A0: len_raddr = p_reg;
            sauc_pkg::OP_A1:
            begin
                lenp_next = len_rdata_reg;
                if (st.drop)
                begin
                    dropped_next = 1'b1;
                end
                else
                begin
                    np_next     = ncount_reg + NW'(1);
                    ncount_next = ncount_reg + NW'(1);
                    len_we      = 1'b1;
                    len_waddr   = ncount_reg + NW'(1);
                    len_wdata   = len_rdata_reg + NW'(1);
                    best_we     = 1'b1;
                    best_waddr  = ncount_reg + NW'(1);
                    k_next      = '0;
                end
            end
            sauc_pkg::OP_CLRNP:
            begin
                tt_we    = 1'b1;
                tt_waddr = sauc_pkg::tt_addr(np_reg, sauc_pkg::SYM_W'(k_reg));
                k_next   = st.k_last ? '0 : k_reg + sauc_pkg::K_W'(1);
            end
            sauc_pkg::OP_WRD:
            begin
                tt_raddr  = sauc_pkg::tt_addr(p_reg, c_reg);
                len_raddr = p_reg;
            end
            sauc_pkg::OP_WCHK:
            begin
                lenp_next = len_rdata_reg;
                if (st.tt_zero)
                begin
                    tt_we      = 1'b1;
                    tt_waddr   = sauc_pkg::tt_addr(p_reg, c_reg);
                    tt_wdata   = np_reg;
                    link_raddr = p_reg;
                end
                else
                begin
                    q_next = tt_rdata_reg;
                end
            end
            sauc_pkg::OP_WLINK:
            begin
                p_next = link_rdata_reg;
                if (st.link_zero)
                begin
                    link_we    = 1'b1;
                    link_waddr = np_reg;
                    link_wdata = sauc_pkg::ROOT_NODE;
                    last_next  = np_reg;
                end
            end
            sauc_pkg::OP_QRD: len_raddr = q_reg;
            sauc_pkg::OP_QCHK:
            begin
                if (st.len_match)
                begin
                    link_we    = 1'b1;
                    link_waddr = np_reg;
                    link_wdata = q_reg;
                    last_next  = np_reg;
                end
                else
                begin
                    cl_next     = ncount_reg + NW'(1);
                    ncount_next = ncount_reg + NW'(1);
                    len_we      = 1'b1;
                    len_waddr   = ncount_reg + NW'(1);
                    len_wdata   = lenp_inc;
                    best_we     = 1'b1;
                    best_waddr  = ncount_reg + NW'(1);
                    link_raddr  = q_reg;
                end
            end
            sauc_pkg::OP_CLLNK:
            begin
                link_we    = 1'b1;
                link_waddr = cl_reg;
                link_wdata = link_rdata_reg;
            end
            sauc_pkg::OP_CLQ:
            begin
                link_we    = 1'b1;
                link_waddr = q_reg;
                link_wdata = cl_reg;
            end
            sauc_pkg::OP_CLNP:
            begin
                link_we    = 1'b1;
                link_waddr = np_reg;
                link_wdata = cl_reg;
                k_next     = '0;
            end
            sauc_pkg::OP_CPRD: tt_raddr = sauc_pkg::tt_addr(q_reg, sauc_pkg::SYM_W'(k_reg));
            sauc_pkg::OP_CPWR:
            begin
                tt_we    = 1'b1;
                tt_waddr = sauc_pkg::tt_addr(cl_reg, sauc_pkg::SYM_W'(k_reg));
                tt_wdata = tt_rdata_reg;
                k_next   = st.k_last ? '0 : k_reg + sauc_pkg::K_W'(1);
            end
            sauc_pkg::OP_RRD: tt_raddr = sauc_pkg::tt_addr(p_reg, c_reg);
            sauc_pkg::OP_RCHK:
            begin
                if (st.redirect)
                begin
                    tt_we      = 1'b1;
                    tt_waddr   = sauc_pkg::tt_addr(p_reg, c_reg);
                    tt_wdata   = cl_reg;
                    link_raddr = p_reg;
                end
                else
                begin
                    last_next = np_reg;
                end
            end
            sauc_pkg::OP_RLINK:
            begin
                p_next = link_rdata_reg;
                if (st.link_zero)
                begin
                    last_next = np_reg;
                end
            end
            sauc_pkg::OP_MRD:
            begin
                tt_raddr  = sauc_pkg::tt_addr(u_reg, c_reg);
                len_raddr = u_reg;
            end
            sauc_pkg::OP_MCHK:
            begin
                if (st.tt_zero)
                begin
                    link_raddr = u_reg;
                end
                else
                begin
                    mlen_next  = clipped + NW'(1);
                    mnode_next = tt_rdata_reg;
                    best_raddr = tt_rdata_reg;
                end
            end
            sauc_pkg::OP_MLINK:
            begin
                u_next = link_rdata_reg;
                if (st.link_zero)
                begin
                    mlen_next  = '0;
                    mnode_next = sauc_pkg::ROOT_NODE;
                end
            end
            sauc_pkg::OP_MBEST:
            begin
                if (best_rdata_reg < mlen_reg)
                begin
                    best_we    = 1'b1;
                    best_waddr = mnode_reg;
                    best_wdata = mlen_reg;
                end
            end
            sauc_pkg::OP_FSTART:
            begin
                total_next = '0;
                i_next     = ncount_reg;
                k_next     = '0;
            end
            sauc_pkg::OP_F1RD:
            begin
                best_raddr = i_reg;
                link_raddr = i_reg;
            end
            sauc_pkg::OP_F1CHK: j_next = link_rdata_reg;
            sauc_pkg::OP_F2RD:
            begin
                best_raddr = j_reg;
                len_raddr  = j_reg;
                link_raddr = j_reg;
            end
            sauc_pkg::OP_F2CHK:
            begin
                if (!st.best_full)
                begin
                    best_we    = 1'b1;
                    best_waddr = j_reg;
                    best_wdata = len_rdata_reg;
                    j_next     = link_rdata_reg;
                end
            end
            sauc_pkg::OP_FNEXT:
            begin
                if (!st.i_two)
                begin
                    i_next = i_reg - NW'(1);
                end
            end
            sauc_pkg::OP_GRD:
            begin
                len_raddr  = i_reg;
                link_raddr = i_reg;
                best_raddr = i_reg;
            end
            sauc_pkg::OP_GMID:
            begin
                leni_next  = len_rdata_reg;
                besti_next = best_rdata_reg;
                len_raddr  = link_rdata_reg;
            end
            sauc_pkg::OP_GCHK:
            begin
                if (leni_reg > besti_reg && leni_reg > floor_v)
                begin
                    total_next = total_reg + sauc_pkg::CNT_W'(leni_reg - floor_v);
                end
                i_next = i_reg + NW'(1);
            end
            sauc_pkg::OP_CLRROOT:
            begin
                tt_we      = 1'b1;
                tt_waddr   = sauc_pkg::tt_addr(sauc_pkg::ROOT_NODE, sauc_pkg::SYM_W'(k_reg));
                link_we    = 1'b1;
                link_waddr = sauc_pkg::ROOT_NODE;
                len_we     = 1'b1;
                len_waddr  = sauc_pkg::ROOT_NODE;
                best_we    = 1'b1;
                best_waddr = sauc_pkg::ROOT_NODE;
                k_next     = st.k_last ? '0 : k_reg + sauc_pkg::K_W'(1);
            end
            sauc_pkg::OP_EMIT:
            begin
                if (!st.out_busy)
                begin
                    ovalid_next  = 1'b1;
                    ocount_next  = total_reg;
                    oovf_next    = dropped_reg;
                    ncount_next  = sauc_pkg::ROOT_NODE;
                    last_next    = sauc_pkg::ROOT_NODE;
                    mnode_next   = sauc_pkg::ROOT_NODE;
                    mlen_next    = '0;
                    dropped_next = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (tt_we) tt_mem[tt_waddr] <= tt_wdata;
        tt_rdata_reg <= tt_mem[tt_raddr];
        if (link_we) link_mem[link_waddr] <= link_wdata;
        link_rdata_reg <= link_mem[link_raddr];
        if (len_we) len_mem[len_waddr] <= len_wdata;
        len_rdata_reg <= len_mem[len_raddr];
        if (best_we) best_mem[best_waddr] <= best_wdata;
        best_rdata_reg <= best_mem[best_raddr];
    end

    always_ff @(posedge clk)
    begin
        p_reg <= p_next; np_reg <= np_next; q_reg <= q_next; cl_reg <= cl_next;
        u_reg <= u_next; j_reg <= j_next; i_reg <= i_next;
        lenp_reg <= lenp_next; leni_reg <= leni_next; besti_reg <= besti_next;
        c_reg <= c_next; total_reg <= total_next;
        ocount_reg <= ocount_next; oovf_reg <= oovf_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg    <= sauc_pkg::ROOT_NODE;
            ncount_reg  <= sauc_pkg::ROOT_NODE;
            mnode_reg   <= sauc_pkg::ROOT_NODE;
            mlen_reg    <= '0;
            k_reg       <= '0;
            dropped_reg <= 1'b0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            last_reg    <= last_next;
            ncount_reg  <= ncount_next;
            mnode_reg   <= mnode_next;
            mlen_reg    <= mlen_next;
            k_reg       <= k_next;
            dropped_reg <= dropped_next;
            ovalid_reg  <= ovalid_next;
        end
    end

    assign out_valid    = ovalid_reg;
    assign out_count    = ocount_reg;
    assign out_overflow = oovf_reg;

endmodule
